[design/priority_task_scheduler_unit_assert.svh]
`ifndef PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH

// implication into the next cycle, sampled on clk, off during rst
`define PTS_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

// implication in the same cycle
`define PTS_ASSERT_NOW(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
    else $error(msg);

`endif

[design/pts_pkg.sv]
package pts_pkg;

  localparam int KIND_W  = 3;
  localparam int PRIO_W  = 2;
  localparam int STATE_W = 2;
  localparam int TASK_W  = 4;
  localparam int TIME_W  = 32;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_SCHED   = 3'd2,
    KIND_DELAY   = 3'd3,
    KIND_SETPRIO = 3'd4,
    KIND_DELETE  = 3'd5,
    KIND_BLOCK   = 3'd6,
    KIND_UNBLOCK = 3'd7
  } kind_t;

  localparam logic [STATE_W-1:0] ST_READY   = 2'd0;
  localparam logic [STATE_W-1:0] ST_PAUSED  = 2'd1;
  localparam logic [STATE_W-1:0] ST_BLOCKED = 2'd2;
  localparam logic [STATE_W-1:0] ST_DELETED = 2'd3;

  localparam logic [PRIO_W-1:0] PRIO_IDLE = 2'd0;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_start;
    logic scan_run;
    logic finish;
  } pts_cmd_t;

  typedef struct packed {
    logic is_sched;
    logic out_free;
    logic scan_done;
  } pts_stat_t;

endpackage

[design/pts_ctrl.sv]
module pts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  pts_pkg::pts_stat_t stat,
  output pts_pkg::pts_cmd_t  cmd
);
  import pts_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    SCAN,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd.capture    = s_tvalid && s_tready;
    cmd.exec       = (state == EXEC) && !stat.is_sched && stat.out_free;
    cmd.scan_start = (state == EXEC) && stat.is_sched;
    cmd.scan_run   = (state == SCAN);
    cmd.finish     = (state == FINISH) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (cmd.capture) begin
          state_next = EXEC;
        end
      end
      EXEC: begin
        if (stat.is_sched) begin
          state_next = SCAN;
        end else if (stat.out_free) begin
          state_next = IDLE;
        end
      end
      SCAN: begin
        if (stat.scan_done) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (stat.out_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      s_tready <= 1'b1;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == IDLE);
    end
  end

endmodule

[design/pts_datapath.sv]
module pts_datapath #(
  parameter int MAX_TASKS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pts_pkg::pts_cmd_t                cmd,
  output pts_pkg::pts_stat_t               stat,
  input  logic [pts_pkg::KIND_W-1:0]       s_tuser,
  input  logic [pts_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pts_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import pts_pkg::*;

  localparam int ID_W = $clog2(MAX_TASKS + 1);
  localparam int AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW   = (ID_W > TASK_W) ? ID_W : TASK_W;
  localparam int PW   = ID_W + 1;

  kind_t               kind;
  logic                handle_valid;
  logic [PRIO_W-1:0]   priority_level;
  logic [STATE_W-1:0]  initial_state;
  logic [TASK_W-1:0]   target_task;
  logic [TIME_W-1:0]   delay_ticks;

  logic [TIME_W-1:0]   tick_count;
  logic [ID_W-1:0]     task_total;
  logic [ID_W-1:0]     current_task;

  logic                out_status;
  logic [TASK_W-1:0]   out_index;

  logic [PRIO_W-1:0]   prio_mem  [MAX_TASKS];
  logic [STATE_W-1:0]  state_mem [MAX_TASKS];
  logic [TIME_W-1:0]   wake_mem  [MAX_TASKS];

  logic [PRIO_W-1:0]   rd_prio;
  logic [STATE_W-1:0]  rd_state;
  logic [TIME_W-1:0]   rd_wake;

  logic [PW-1:0]       rd_id;
  logic                ev_valid;
  logic [ID_W-1:0]     ev_id;
  logic [PRIO_W-1:0]   best_prio;
  logic [ID_W-1:0]     best_id;

  logic                cur_ok;
  logic                tgt_ok;
  logic                add_ok;
  logic [CW-1:0]       tgt_ext;
  logic [AW-1:0]       cur_addr;
  logic [AW-1:0]       tgt_addr;
  logic [AW-1:0]       total_addr;
  logic [AW-1:0]       ev_addr;
  logic [AW-1:0]       rd_addr;
  logic                more;
  logic                issue;
  logic                wake_up;
  logic                better;

  logic                prio_we;
  logic [AW-1:0]       prio_waddr;
  logic [PRIO_W-1:0]   prio_wdata;
  logic                state_we;
  logic [AW-1:0]       state_waddr;
  logic [STATE_W-1:0]  state_wdata;
  logic                wake_we;
  logic [AW-1:0]       wake_waddr;
  logic [TIME_W-1:0]   wake_wdata;

  logic                res_status;
  logic [TASK_W-1:0]   res_index;

  always_comb begin
    tgt_ext    = CW'(target_task);
    cur_ok     = (current_task != '0) && (current_task <= task_total);
    tgt_ok     = (tgt_ext != '0) && (tgt_ext <= CW'(task_total));
    add_ok     = handle_valid && (task_total != ID_W'(MAX_TASKS));
    cur_addr   = AW'(current_task - ID_W'(1));
    tgt_addr   = AW'(tgt_ext - CW'(1));
    total_addr = AW'(task_total);
    ev_addr    = AW'(ev_id - ID_W'(1));
    rd_addr    = AW'(rd_id - PW'(1));
    more       = (rd_id <= PW'(task_total));
    issue      = cmd.scan_run && more;
    wake_up    = ev_valid && (rd_state == ST_PAUSED) && (tick_count > rd_wake);
    better     = ev_valid && ((rd_state == ST_READY) || wake_up) && (rd_prio > best_prio);
  end

  always_comb begin
    stat.is_sched  = (kind == KIND_SCHED);
    stat.out_free  = !m_tvalid || m_tready;
    stat.scan_done = !more && !ev_valid;
  end

  always_comb begin
    prio_we     = 1'b0;
    prio_waddr  = cur_addr;
    prio_wdata  = priority_level;
    state_we    = 1'b0;
    state_waddr = cur_addr;
    state_wdata = ST_READY;
    wake_we     = 1'b0;
    wake_waddr  = cur_addr;
    wake_wdata  = '0;
    res_status  = 1'b0;
    res_index   = TASK_W'(current_task);
    if (wake_up) begin
      state_we    = 1'b1;
      state_waddr = ev_addr;
      state_wdata = ST_READY;
      wake_we     = 1'b1;
      wake_waddr  = ev_addr;
      wake_wdata  = '0;
    end
    if (cmd.exec) begin
      case (kind)
        KIND_ADD: begin
          if (add_ok) begin
            prio_we     = 1'b1;
            prio_waddr  = total_addr;
            state_we    = 1'b1;
            state_waddr = total_addr;
            state_wdata = initial_state;
            wake_we     = 1'b1;
            wake_waddr  = total_addr;
            wake_wdata  = '0;
            res_index   = TASK_W'(ID_W'(task_total + ID_W'(1)));
          end else begin
            res_status  = 1'b1;
            res_index   = '0;
          end
        end
        KIND_DELAY: begin
          state_we    = cur_ok;
          state_wdata = ST_PAUSED;
          wake_we     = cur_ok;
          wake_wdata  = tick_count + delay_ticks;
        end
        KIND_SETPRIO: begin
          prio_we = cur_ok && (priority_level != PRIO_IDLE);
        end
        KIND_DELETE: begin
          state_we    = cur_ok;
          state_wdata = ST_DELETED;
        end
        KIND_BLOCK: begin
          state_we    = tgt_ok;
          state_waddr = tgt_addr;
          state_wdata = ST_BLOCKED;
          res_status  = !tgt_ok;
        end
        KIND_UNBLOCK: begin
          state_we    = tgt_ok;
          state_waddr = tgt_addr;
          state_wdata = ST_READY;
          res_status  = !tgt_ok;
        end
        default: begin
          res_status = 1'b0;
        end
      endcase
    end
    if (cmd.finish) begin
      res_index = TASK_W'(best_id);
    end
  end

  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[prio_waddr] <= prio_wdata;
    end
    if (state_we) begin
      state_mem[state_waddr] <= state_wdata;
    end
    if (wake_we) begin
      wake_mem[wake_waddr] <= wake_wdata;
    end
    rd_prio  <= prio_mem[rd_addr];
    rd_state <= state_mem[rd_addr];
    rd_wake  <= wake_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind           <= kind_t'(s_tuser);
      handle_valid   <= s_tdata[0];
      priority_level <= s_tdata[2:1];
      initial_state  <= s_tdata[4:3];
      target_task    <= s_tdata[8:5];
      delay_ticks    <= s_tdata[40:9];
    end
    if (cmd.exec || cmd.finish) begin
      out_status <= res_status;
      out_index  <= res_index;
    end
    if (cmd.scan_start) begin
      best_prio <= PRIO_IDLE;
      best_id   <= '0;
    end else if (better) begin
      best_prio <= rd_prio;
      best_id   <= ev_id;
    end
    ev_id <= ID_W'(rd_id);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      task_total   <= '0;
      current_task <= '0;
      m_tvalid     <= 1'b0;
      rd_id        <= PW'(1);
      ev_valid     <= 1'b0;
    end else begin
      if (cmd.exec && (kind == KIND_TICK)) begin
        tick_count <= tick_count + TIME_W'(1);
      end
      if (cmd.exec && (kind == KIND_ADD) && add_ok) begin
        task_total <= task_total + ID_W'(1);
      end
      if (cmd.finish) begin
        current_task <= best_id;
      end
      if (cmd.exec || cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.scan_start) begin
        rd_id <= PW'(1);
      end else if (issue) begin
        rd_id <= rd_id + PW'(1);
      end
      ev_valid <= issue;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - TASK_W - 1){1'b0}}, out_index, out_status};

endmodule

[design/priority_task_scheduler_unit.sv]
// Channel  Dir  Bus fields
// s_       in   tuser: kind[2:0]; tdata: handle_valid, priority_level, initial_state,
//               target_task, delay_ticks, zero fill to 48 bits
// m_       out  tdata: status, task_index, zero fill to 8 bits
//
// Schedule: the scan reads task entries 1 to task_total, one per cycle, through the registered
// read port of the task memories; the final step then loads the result.
// Every other command loads its result in its execute step.
// One command is in work at a time; s_tready rises at the edge that loads the result.
// A result waiting on m_tready holds the next command in its execute or final step.
// rst is synchronous; it clears tick count, task count and current task (idle).
module priority_task_scheduler_unit #(
  parameter int MAX_TASKS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // kind
  input  logic [pts_pkg::KIND_W-1:0]      s_tuser,
  // handle_valid[0], priority_level[2:1], initial_state[4:3], target_task[8:5],
  // delay_ticks[40:9]
  input  logic [pts_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[0], task_index[4:1]
  output logic [pts_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import pts_pkg::*;

  pts_cmd_t  cmd;
  pts_stat_t stat;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pts_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[design/pts_checker.sv]
`include "priority_task_scheduler_unit_assert.svh"

module pts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pts_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import pts_pkg::*;

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // commands accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `PTS_ASSERT_NEXT(a_one_in_work, in_acc, !s_tready, "ready while a command is in work")
  `PTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
  `PTS_ASSERT_NOW(a_no_invented, m_tvalid, pending != 2'd0, "result without a command")
  `PTS_ASSERT_NOW(a_ready_drained, s_tready, pending <= 2'd1, "ready with a command in work")

endmodule

bind priority_task_scheduler_unit pts_checker u_pts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import pts_pkg::*;

  localparam int TASK_SLOTS = 8;
  localparam int PER_PHASE = 525;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 40;

  localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_MEDIUM = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd3;

  typedef struct packed {
    logic             status;
    logic [TASK_W-1:0] index;
  } reply_t;

  class sched_scoreboard;
    logic [TIME_W-1:0]  now_ticks;
    int unsigned        live_tasks;
    logic [TASK_W-1:0]  running;
    logic [PRIO_W-1:0]  prio_of [1:TASK_SLOTS];
    logic [STATE_W-1:0] state_of [1:TASK_SLOTS];
    logic [TIME_W-1:0]  wake_at [1:TASK_SLOTS];
    reply_t             awaited[$];

    function new();
      now_ticks = '0;
      live_tasks = 0;
      running = '0;
    endfunction

    function bit slot_ok(logic [TASK_W-1:0] id);
      return id >= 1 && id <= live_tasks;
    endfunction

    function logic [TASK_W-1:0] pick_ready();
      for (int p = 3; p >= 1; p--) begin
        for (int id = 1; id <= live_tasks; id++) begin
          if (prio_of[id] == p && state_of[id] == ST_READY) return id[TASK_W-1:0];
        end
      end
      return '0;
    endfunction

    function void accept_command(kind_t k, logic [IN_DATA_W-1:0] d);
      logic               h;
      logic [PRIO_W-1:0]  p;
      logic [STATE_W-1:0] s;
      logic [TASK_W-1:0]  tgt;
      logic [TIME_W-1:0]  dly;
      reply_t             r;
      h = d[0];
      p = d[2:1];
      s = d[4:3];
      tgt = d[8:5];
      dly = d[40:9];
      r.status = 1'b0;
      r.index = running;
      case (k)
        KIND_TICK: now_ticks = now_ticks + 1;
        KIND_ADD: begin
          if (live_tasks < TASK_SLOTS && h) begin
            live_tasks++;
            prio_of[live_tasks] = p;
            state_of[live_tasks] = s;
            wake_at[live_tasks] = '0;
            r.index = live_tasks[TASK_W-1:0];
          end else begin
            r.status = 1'b1;
            r.index = '0;
          end
        end
        KIND_SCHED: begin
          for (int id = 1; id <= live_tasks; id++) begin
            if (state_of[id] == ST_PAUSED && now_ticks > wake_at[id]) begin
              state_of[id] = ST_READY;
              wake_at[id] = '0;
            end
          end
          running = pick_ready();
          r.index = running;
        end
        KIND_DELAY: begin
          if (slot_ok(running)) begin
            wake_at[running] = now_ticks + dly;
            state_of[running] = ST_PAUSED;
          end
        end
        KIND_SETPRIO: begin
          if (slot_ok(running) && p != PRIO_IDLE) prio_of[running] = p;
        end
        KIND_DELETE: begin
          if (slot_ok(running)) state_of[running] = ST_DELETED;
        end
        KIND_BLOCK: begin
          if (slot_ok(tgt)) state_of[tgt] = ST_BLOCKED;
          else r.status = 1'b1;
        end
        default: begin
          if (slot_ok(tgt)) state_of[tgt] = ST_READY;
          else r.status = 1'b1;
        end
      endcase
      awaited.push_back(r);
    endfunction

    function bit check_result(logic st, logic [TASK_W-1:0] idx, output string why);
      reply_t want;
      if (awaited.size() == 0) begin
        why = $sformatf("unexpected result status=%0d index=%0d", st, idx);
        return 1'b0;
      end
      want = awaited.pop_front();
      why = "";
      if (st !== want.status)
        why = $sformatf("status got %0d want %0d; ", st, want.status);
      if (idx !== want.index)
        why = {why, $sformatf("task_index got %0d want %0d", idx, want.index)};
      return why == "";
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  sched_scoreboard board = new();
  int    src_idle_pct = 38;
  int    sink_idle_pct = 86;
  int    mismatches = 0;
  int    cycles = 0;
  string why;

  priority_task_scheduler_unit #(.MAX_TASKS(TASK_SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (!board.check_result(m_tdata[0], m_tdata[4:1], why)) report_mismatch(why);
    end
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic logic [IN_DATA_W-1:0] pack_cmd(logic h, logic [PRIO_W-1:0] p,
                                                     logic [STATE_W-1:0] s,
                                                     logic [TASK_W-1:0] t,
                                                     logic [TIME_W-1:0] d);
    return {7'd0, d, t, s, p, h};
  endfunction

  task automatic issue(kind_t k, logic h, logic [PRIO_W-1:0] p, logic [STATE_W-1:0] s,
                       logic [TASK_W-1:0] t, logic [TIME_W-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= pack_cmd(h, p, s, t, d);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.accept_command(k, pack_cmd(h, p, s, t, d));
  endtask

  task automatic issue_random();
    kind_t             k;
    int                r;
    logic [TASK_W-1:0] tgt;
    logic [TIME_W-1:0] dly;
    r = $urandom_range(99);
    if (r < 20) k = KIND_TICK;
    else if (r < 28) k = KIND_ADD;
    else if (r < 52) k = KIND_SCHED;
    else if (r < 64) k = KIND_DELAY;
    else if (r < 72) k = KIND_SETPRIO;
    else if (r < 77) k = KIND_DELETE;
    else if (r < 87) k = KIND_BLOCK;
    else k = KIND_UNBLOCK;
    tgt = ($urandom_range(7) == 0) ? TASK_W'($urandom_range(15)) : TASK_W'($urandom_range(9));
    dly = ($urandom_range(7) == 0) ? $urandom : TIME_W'($urandom_range(6));
    issue(k, 1'($urandom_range(1)), PRIO_W'($urandom_range(3)), STATE_W'($urandom_range(3)),
          tgt, dly);
  endtask

  // hold off new commands until every reply is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    issue(KIND_SCHED, 1'b0, PRIO_IDLE, ST_READY, 4'd0, 32'd0);
    issue(KIND_ADD, 1'b0, PRIO_HIGH, ST_READY, 4'd0, 32'd0);
    issue(KIND_DELAY, 1'b1, PRIO_HIGH, ST_DELETED, 4'd15, 32'hFFFF_FFFF);
    issue(KIND_SETPRIO, 1'b0, PRIO_HIGH, ST_READY, 4'd0, 32'd0);
    issue(KIND_DELETE, 1'b0, PRIO_IDLE, ST_READY, 4'd0, 32'd0);
    issue(KIND_BLOCK, 1'b0, PRIO_IDLE, ST_READY, 4'd0, 32'd0);
    issue(KIND_UNBLOCK, 1'b0, PRIO_IDLE, ST_READY, 4'd1, 32'd0);
    issue(KIND_ADD, 1'b1, PRIO_HIGH, ST_READY, 4'd0, 32'd0);
    issue(KIND_ADD, 1'b1, PRIO_IDLE, ST_READY, 4'd0, 32'd0);
    issue(KIND_ADD, 1'b1, PRIO_MEDIUM, ST_PAUSED, 4'd0, 32'd0);
    issue(KIND_ADD, 1'b1, PRIO_LOW, ST_BLOCKED, 4'd0, 32'd0);
    issue(KIND_ADD, 1'b1, PRIO_HIGH, ST_DELETED, 4'd0, 32'd0);
    issue(KIND_ADD, 1'b1, PRIO_LOW, ST_READY, 4'd0, 32'd0);
    issue(KIND_ADD, 1'b1, PRIO_MEDIUM, ST_READY, 4'd0, 32'd0);
    issue(KIND_ADD, 1'b1, PRIO_HIGH, ST_READY, 4'd15, 32'hFFFF_FFFF);
    issue(KIND_ADD, 1'b1, PRIO_LOW, ST_READY, 4'd0, 32'd0);
    issue(KIND_BLOCK, 1'b0, PRIO_IDLE, ST_READY, 4'd15, 32'd0);
    issue(KIND_SCHED, 1'b0, PRIO_IDLE, ST_READY, 4'd0, 32'd0);
    issue(KIND_SETPRIO, 1'b0, PRIO_IDLE, ST_READY, 4'd0, 32'd0);
    issue(KIND_SETPRIO, 1'b0, PRIO_LOW, ST_READY, 4'd0, 32'd0);
    issue(KIND_TICK, 1'b0, PRIO_IDLE, ST_READY, 4'd0, 32'd0);
    issue(KIND_DELAY, 1'b0, PRIO_IDLE, ST_READY, 4'd0, 32'hFFFF_FFFF);
    issue(KIND_SCHED, 1'b0, PRIO_IDLE, ST_READY, 4'd0, 32'd0);
    issue(KIND_DELETE, 1'b0, PRIO_IDLE, ST_READY, 4'd0, 32'd0);
    issue(KIND_UNBLOCK, 1'b0, PRIO_IDLE, ST_READY, 4'd5, 32'd0);
    issue(KIND_BLOCK, 1'b0, PRIO_IDLE, ST_READY, 4'd8, 32'd0);
    issue(KIND_UNBLOCK, 1'b0, PRIO_IDLE, ST_READY, 4'd9, 32'd0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 38;
          sink_idle_pct = 86;
          run_directed();
        end
        1: begin
          src_idle_pct = 86;
          sink_idle_pct = 38;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      repeat (PER_PHASE) issue_random();
      drain();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[priority_task_scheduler_unit.f]
+incdir+design
design/pts_pkg.sv
design/pts_ctrl.sv
design/pts_datapath.sv
design/priority_task_scheduler_unit.sv
design/pts_checker.sv
bench/tb.sv
